FILE: rtl/core/nrcl_pkg.sv
// ----------------------------------------------------------------------------
// nrcl_pkg
// Shared types and constants for the narrowest-range calibration lookup.
// ----------------------------------------------------------------------------
package nrcl_pkg;

    localparam int NRCL_MAX_ENTRIES = 256;

    localparam int MODULE_W = 10;
    localparam int KEY_W    = MODULE_W + 1;
    localparam int RUN_W    = 16;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // One stored calibration entry.
    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [RUN_W-1:0]         range_begin;
        logic [RUN_W-1:0]         range_end;
        logic signed [DATA_W-1:0] mean;
        logic signed [DATA_W-1:0] sigma;
    } entry_t;

    // Control from the sequencer to the best-match tracker.
    typedef struct packed {
        logic clear;
        logic check;
    } scan_ctl_t;

    // Running best match of a lookup.
    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] mean;
        logic signed [DATA_W-1:0] sigma;
    } best_t;

endpackage

FILE: rtl/core/nrcl_if.sv
// ----------------------------------------------------------------------------
// nrcl_req_if / nrcl_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface nrcl_req_if
    import nrcl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [MODULE_W-1:0]      module_req;
    logic                     side;
    logic [RUN_W-1:0]         range_begin;
    logic [RUN_W-1:0]         range_end;
    logic signed [DATA_W-1:0] mean_in;
    logic signed [DATA_W-1:0] sigma_in;

    modport source (
        output valid, opcode, module_req, side, range_begin, range_end, mean_in, sigma_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, module_req, side, range_begin, range_end, mean_in, sigma_in,
        output ready
    );
endinterface

interface nrcl_rsp_if
    import nrcl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] mean_out;
    logic signed [DATA_W-1:0] sigma_out;

    modport source (
        output valid, status, mean_out, sigma_out,
        input  ready
    );
    modport sink (
        input  valid, status, mean_out, sigma_out,
        output ready
    );
endinterface

FILE: rtl/core/nrcl_ram.sv
// ----------------------------------------------------------------------------
// nrcl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nrcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/nrcl_best.sv
// ----------------------------------------------------------------------------
// nrcl_best
// Best-match tracker: checks one entry per cycle against the lookup key and
// run, and keeps the narrowest containing range seen so far.
// ----------------------------------------------------------------------------
module nrcl_best
    import nrcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctl_t        ctl,
    input  entry_t           entry,
    input  logic [KEY_W-1:0] key,
    input  logic [RUN_W-1:0] run,
    output best_t            best
);

    logic                     found_reg, found_next;
    logic [RUN_W-1:0]         width_reg, width_next;
    logic signed [DATA_W-1:0] mean_reg, mean_next;
    logic signed [DATA_W-1:0] sigma_reg, sigma_next;
    logic                     hit;
    logic [RUN_W-1:0]         width;

    // A reversed range can never contain the run, so the width is only used
    // when end >= begin and needs no extra bit.
    assign hit   = (entry.key == key) && (run >= entry.range_begin) &&
                   (run <= entry.range_end);
    assign width = entry.range_end - entry.range_begin;

    always_comb
    begin
        found_next = found_reg;
        width_next = width_reg;
        mean_next  = mean_reg;
        sigma_next = sigma_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctl.check && hit && (!found_reg || width < width_reg))
        begin
            // Strictly narrower only, so the earlier entry wins a tie.
            found_next = 1'b1;
            width_next = width;
            mean_next  = entry.mean;
            sigma_next = entry.sigma;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        mean_reg  <= mean_next;
        sigma_reg <= sigma_next;
    end

    assign best.found = found_reg;
    assign best.mean  = mean_reg;
    assign best.sigma = sigma_reg;

endmodule

FILE: rtl/core/narrowest_range_calibration_lookup_core.sv
// ----------------------------------------------------------------------------
// narrowest_range_calibration_lookup_core
// Calibration table with clear, append and narrowest-range lookup by key.
// ----------------------------------------------------------------------------
// The block takes request items on the req channel and returns exactly one
// result item per request on the rsp channel; both are valid/ready channels.
// The current run number is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
//
// Clear and insert items, and a lookup on an empty table, need no scan: the
// accepted item sets the result registers, passes to the result state and
// from there into the output register. A lookup reads the entry memory once
// per cycle, one entry per cycle over the N entries stored so far, then
// passes through the drain, pick and result states before its result moves
// into the output register. The single read port of the entry memory sets
// this pace. Ready is high again as soon as the result has moved into the
// output register, so the next item can be taken while the previous result
// still waits there. If the receiver stalls, a finished result waits in the
// sequencer until the output register frees.
//
// Reset empties the table (entry count zero), sets the run to zero and drops
// any pending result. The memory itself is not cleared: only the first N
// entries are ever read.
// ----------------------------------------------------------------------------
module narrowest_range_calibration_lookup_core
    import nrcl_pkg::*;
#(
    parameter int MAX_ENTRIES = NRCL_MAX_ENTRIES
) (
    input  logic             clk,
    input  logic             rst_n,
    nrcl_req_if.sink         req,
    nrcl_rsp_if.source       rsp,
    input  logic             cfg_wr_en,
    input  logic [RUN_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_RESULT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                     rd_pending_reg;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [RUN_W-1:0]         run_reg;
    logic [1:0]               res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_mean_reg, res_mean_next;
    logic signed [DATA_W-1:0] res_sigma_reg, res_sigma_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [1:0]               rsp_status_reg, rsp_status_next;
    logic signed [DATA_W-1:0] rsp_mean_reg, rsp_mean_next;
    logic signed [DATA_W-1:0] rsp_sigma_reg, rsp_sigma_next;

    logic       accept;
    logic       out_free;
    logic       last_read;
    logic       ram_we;
    entry_t     wr_entry;
    entry_t     rd_entry;
    logic [$bits(entry_t)-1:0] rd_bits;
    scan_ctl_t  scan_ctl;
    best_t      best;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign last_read = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg;

    // Writes happen only in the idle state and reads only during a scan, so
    // the two ports never touch the same entry in the same cycle.
    assign ram_we = accept && (req.opcode == OP_INSERT) &&
                    (count_reg != CNT_W'(MAX_ENTRIES));

    assign wr_entry.key         = {req.side, req.module_req};
    assign wr_entry.range_begin = req.range_begin;
    assign wr_entry.range_end   = req.range_end;
    assign wr_entry.mean        = req.mean_in;
    assign wr_entry.sigma       = req.sigma_in;

    nrcl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_entry),
        .re    (state_reg == S_SCAN),
        .raddr (scan_idx_reg),
        .rdata (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    // The tracker starts fresh when a lookup is accepted and checks each entry
    // in the cycle its read data arrives.
    assign scan_ctl.clear = accept && (req.opcode == OP_LOOKUP);
    assign scan_ctl.check = rd_pending_reg;

    nrcl_best u_best (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .entry (rd_entry),
        .key   (key_reg),
        .run   (run_reg),
        .best  (best)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_mean_next   = res_mean_reg;
        res_sigma_next  = res_sigma_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_mean_next   = rsp_mean_reg;
        rsp_sigma_next  = rsp_sigma_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next        = {req.side, req.module_req};
                    res_status_next = STATUS_OK;
                    res_mean_next   = '0;
                    res_sigma_next  = '0;
                    state_next      = S_RESULT;
                    case (req.opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // The unused opcode leaves the table alone.
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (last_read)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + ADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                // The last entry is checked in this cycle.
                state_next = S_PICK;
            end
            S_PICK:
            begin
                res_status_next = best.found ? STATUS_OK : STATUS_NOT_FOUND;
                res_mean_next   = best.found ? best.mean : '0;
                res_sigma_next  = best.found ? best.sigma : '0;
                state_next      = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_mean_next   = res_mean_reg;
                    rsp_sigma_next  = res_sigma_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_pending_reg <= 1'b0;
            run_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_pending_reg <= (state_reg == S_SCAN);
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                run_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_mean_reg   <= res_mean_next;
        res_sigma_reg  <= res_sigma_next;
        rsp_status_reg <= rsp_status_next;
        rsp_mean_reg   <= rsp_mean_next;
        rsp_sigma_reg  <= rsp_sigma_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.mean_out  = rsp_mean_reg;
    assign rsp.sigma_out = rsp_sigma_reg;

endmodule
